@@ sv/dad_pkg.sv @@
`timescale 1ns / 1ps

package dad_pkg;

  localparam int MaxFrameDim = 4096;
  localparam int KeptClasses = 6;
  localparam int ScoreFields = 6;

  localparam int CoordW  = 16;
  localparam int SizeW   = 15;
  localparam int ScoreW  = 16;
  localparam int PadW    = 11;
  localparam int InvW    = 20;
  localparam int DimW    = 13;
  localparam int EdgeW   = 12;
  localparam int ClassW  = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 20;

  localparam int NumW     = 19;
  localparam int ProdW    = NumW + InvW + 1;
  localparam int FracBits = 21;
  localparam int QuotW    = ProdW - FracBits;
  localparam int LimW     = $clog2(MaxFrameDim);
  localparam int WinW     = $clog2(ScoreFields);

  localparam logic [ScoreW-1:0] ConfThresholdRst = 16'd26214;
  localparam logic [PadW-1:0]   PadLeftRst       = 11'd0;
  localparam logic [PadW-1:0]   PadTopRst        = 11'd140;
  localparam logic [InvW-1:0]   InvScaleRst      = 20'd196608;
  localparam logic [DimW-1:0]   FrameWidthRst    = 13'd1920;
  localparam logic [DimW-1:0]   FrameHeightRst   = 13'd1080;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CONF_THRESHOLD = 3'd0,
    REG_PAD_LEFT       = 3'd1,
    REG_PAD_TOP        = 3'd2,
    REG_INV_SCALE      = 3'd3,
    REG_FRAME_WIDTH    = 3'd4,
    REG_FRAME_HEIGHT   = 3'd5
  } cfg_reg_t;

  typedef enum logic [ClassW-1:0] {
    CLS_PERSON     = 3'd0,
    CLS_BICYCLE    = 3'd1,
    CLS_CAR        = 3'd2,
    CLS_MOTORCYCLE = 3'd3,
    CLS_BUS        = 3'd5,
    CLS_TRUCK      = 3'd7
  } class_code_t;

  typedef logic [ScoreFields-1:0][ScoreW-1:0] score_arr_t;

  function automatic logic [ClassW-1:0] slot_class(input logic [WinW-1:0] idx);
    logic [ClassW-1:0] id;
    case (idx)
      WinW'(0): id = CLS_PERSON;
      WinW'(1): id = CLS_BICYCLE;
      WinW'(2): id = CLS_CAR;
      WinW'(3): id = CLS_MOTORCYCLE;
      WinW'(4): id = CLS_BUS;
      WinW'(5): id = CLS_TRUCK;
      default:  id = CLS_PERSON;
    endcase
    return id;
  endfunction

  function automatic logic [LimW-1:0] dim_limit(input logic [DimW-1:0] dim);
    logic [LimW-1:0] lim;
    if (dim == '0) begin
      lim = '0;
    end else if (int'(dim) > MaxFrameDim) begin
      lim = LimW'(MaxFrameDim - 1);
    end else begin
      lim = LimW'(dim - DimW'(1));
    end
    return lim;
  endfunction

endpackage

@@ sv/dad_if.sv @@
`timescale 1ns / 1ps

interface dad_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dad_pkg::CoordW-1:0]     centre_x;
  logic signed [dad_pkg::CoordW-1:0]     centre_y;
  logic        [dad_pkg::SizeW-1:0]      box_width;
  logic        [dad_pkg::SizeW-1:0]      box_height;
  logic        [dad_pkg::ScoreW-1:0]     score_person;
  logic        [dad_pkg::ScoreW-1:0]     score_bicycle;
  logic        [dad_pkg::ScoreW-1:0]     score_car;
  logic        [dad_pkg::ScoreW-1:0]     score_motorcycle;
  logic        [dad_pkg::ScoreW-1:0]     score_bus;
  logic        [dad_pkg::ScoreW-1:0]     score_truck;

  modport source (
    output valid, centre_x, centre_y, box_width, box_height, score_person,
           score_bicycle, score_car, score_motorcycle, score_bus, score_truck,
    input  ready
  );
  modport sink (
    input  valid, centre_x, centre_y, box_width, box_height, score_person,
           score_bicycle, score_car, score_motorcycle, score_bus, score_truck,
    output ready
  );
endinterface

interface dad_out_if;
  logic                          valid;
  logic                          ready;
  logic [dad_pkg::EdgeW-1:0]     left;
  logic [dad_pkg::EdgeW-1:0]     top;
  logic [dad_pkg::EdgeW-1:0]     right;
  logic [dad_pkg::EdgeW-1:0]     bottom;
  logic [dad_pkg::ClassW-1:0]    class_code;
  logic [dad_pkg::ScoreW-1:0]    win_score;

  modport source (
    output valid, left, top, right, bottom, class_code, win_score,
    input  ready
  );
  modport sink (
    input  valid, left, top, right, bottom, class_code, win_score,
    output ready
  );
endinterface

@@ sv/detection_anchor_decode_top.sv @@
`timescale 1ns / 1ps

// Decodes one detector anchor per cycle, unless in_chan.ready is low, into a
// frame-space box. An item passes an input register, a stage that picks the
// best class score and forms the four pad-corrected edge numerators, a stage
// with the four 19x21 bit multipliers against inv_scale, and a clamp stage
// feeding the output register. Anchors with no nonzero score or a best score
// below conf_threshold leave no result and only a bubble. in_chan.ready drops
// only when all four stages hold items and the output is stalled. The user
// must write configuration through cfg_we, cfg_index and cfg_wdata only
// while no item is in flight; the block itself does not enforce it.
// Unknown indexes are ignored.

module detection_anchor_decode_top (
  input  logic                          clk,
  input  logic                          rst_n,
  dad_in_if.sink                        in_chan,
  dad_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [dad_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dad_pkg::CfgDataW-1:0]  cfg_wdata
);

  // configuration registers
  logic [dad_pkg::ScoreW-1:0] conf_threshold_r;
  logic [dad_pkg::PadW-1:0]   pad_left_r;
  logic [dad_pkg::PadW-1:0]   pad_top_r;
  logic [dad_pkg::InvW-1:0]   inv_scale_r;
  logic [dad_pkg::DimW-1:0]   frame_width_r;
  logic [dad_pkg::DimW-1:0]   frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conf_threshold_r <= dad_pkg::ConfThresholdRst;
      pad_left_r       <= dad_pkg::PadLeftRst;
      pad_top_r        <= dad_pkg::PadTopRst;
      inv_scale_r      <= dad_pkg::InvScaleRst;
      frame_width_r    <= dad_pkg::FrameWidthRst;
      frame_height_r   <= dad_pkg::FrameHeightRst;
    end else if (cfg_we) begin
      case (dad_pkg::cfg_reg_t'(cfg_index))
        dad_pkg::REG_CONF_THRESHOLD: conf_threshold_r <= cfg_wdata[dad_pkg::ScoreW-1:0];
        dad_pkg::REG_PAD_LEFT:       pad_left_r       <= cfg_wdata[dad_pkg::PadW-1:0];
        dad_pkg::REG_PAD_TOP:        pad_top_r        <= cfg_wdata[dad_pkg::PadW-1:0];
        dad_pkg::REG_INV_SCALE:      inv_scale_r      <= cfg_wdata[dad_pkg::InvW-1:0];
        dad_pkg::REG_FRAME_WIDTH:    frame_width_r    <= cfg_wdata[dad_pkg::DimW-1:0];
        dad_pkg::REG_FRAME_HEIGHT:   frame_height_r   <= cfg_wdata[dad_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  // stage enables
  logic v1_r, v2_r, v3_r, out_v_r;
  logic en1, en2, en3, en4;

  assign en4 = !out_v_r || out_chan.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_chan.ready = en1;

  // stage 1: input register
  logic signed [dad_pkg::CoordW-1:0] cx_r, cy_r;
  logic [dad_pkg::SizeW-1:0]         bw_r, bh_r;
  dad_pkg::score_arr_t               score_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      cx_r       <= in_chan.centre_x;
      cy_r       <= in_chan.centre_y;
      bw_r       <= in_chan.box_width;
      bh_r       <= in_chan.box_height;
      score_r[0] <= in_chan.score_person;
      score_r[1] <= in_chan.score_bicycle;
      score_r[2] <= in_chan.score_car;
      score_r[3] <= in_chan.score_motorcycle;
      score_r[4] <= in_chan.score_bus;
      score_r[5] <= in_chan.score_truck;
    end
  end

  // stage 2: class pick and edge numerators
  logic [dad_pkg::ScoreW-1:0] best;
  logic [dad_pkg::WinW-1:0]   win;
  logic                       found;
  logic                       keep;

  always_comb begin
    best  = '0;
    win   = '0;
    found = 1'b0;
    for (int i = 0; i < dad_pkg::ScoreFields; i++) begin
      if (i < dad_pkg::KeptClasses && score_r[i] > best) begin
        best  = score_r[i];
        win   = dad_pkg::WinW'(i);
        found = 1'b1;
      end
    end
    keep = found && (best >= conf_threshold_r);
  end

  logic signed [dad_pkg::NumW-1:0] cx2, cy2, bw_e, bh_e, px_e, py_e;
  assign cx2  = {{2{cx_r[dad_pkg::CoordW-1]}}, cx_r, 1'b0};
  assign cy2  = {{2{cy_r[dad_pkg::CoordW-1]}}, cy_r, 1'b0};
  assign bw_e = {4'b0, bw_r};
  assign bh_e = {4'b0, bh_r};
  assign px_e = {3'b0, pad_left_r, 5'b0};
  assign py_e = {3'b0, pad_top_r, 5'b0};

  logic signed [dad_pkg::NumW-1:0] num_l_r, num_t_r, num_rt_r, num_b_r;
  logic [dad_pkg::ClassW-1:0]      cls2_r, cls3_r;
  logic [dad_pkg::ScoreW-1:0]      best2_r, best3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      num_l_r  <= cx2 - bw_e - px_e;
      num_t_r  <= cy2 - bh_e - py_e;
      num_rt_r <= cx2 + bw_e - px_e;
      num_b_r  <= cy2 + bh_e - py_e;
      cls2_r   <= dad_pkg::slot_class(win);
      best2_r  <= best;
    end
  end

  // stage 3: scale
  logic signed [dad_pkg::InvW:0]    inv_s;
  logic signed [dad_pkg::ProdW-1:0] prod_l_r, prod_t_r, prod_rt_r, prod_b_r;
  assign inv_s = $signed({1'b0, inv_scale_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      prod_l_r  <= num_l_r * inv_s;
      prod_t_r  <= num_t_r * inv_s;
      prod_rt_r <= num_rt_r * inv_s;
      prod_b_r  <= num_b_r * inv_s;
      cls3_r    <= cls2_r;
      best3_r   <= best2_r;
    end
  end

  // stage 4: clamp into the output register
  logic [dad_pkg::LimW-1:0] lim_x, lim_y;
  assign lim_x = dad_pkg::dim_limit(frame_width_r);
  assign lim_y = dad_pkg::dim_limit(frame_height_r);

  function automatic logic [dad_pkg::EdgeW-1:0] clamp_edge(
    input logic signed [dad_pkg::ProdW-1:0] prod,
    input logic [dad_pkg::LimW-1:0]         lim
  );
    logic [dad_pkg::QuotW-1:0] q;
    logic [dad_pkg::QuotW-1:0] lim_e;
    logic [dad_pkg::QuotW-1:0] res;
    q     = prod[dad_pkg::ProdW-1:dad_pkg::FracBits];
    lim_e = dad_pkg::QuotW'(lim);
    if (prod[dad_pkg::ProdW-1] || prod == '0) begin
      res = '0;
    end else if (q > lim_e) begin
      res = lim_e;
    end else begin
      res = q;
    end
    return res[dad_pkg::EdgeW-1:0];
  endfunction

  logic [dad_pkg::EdgeW-1:0]  left_r, top_r, right_r, bottom_r;
  logic [dad_pkg::ClassW-1:0] cls_out_r;
  logic [dad_pkg::ScoreW-1:0] best_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en4) begin
      out_v_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      left_r     <= clamp_edge(prod_l_r, lim_x);
      top_r      <= clamp_edge(prod_t_r, lim_y);
      right_r    <= clamp_edge(prod_rt_r, lim_x);
      bottom_r   <= clamp_edge(prod_b_r, lim_y);
      cls_out_r  <= cls3_r;
      best_out_r <= best3_r;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.left       = left_r;
  assign out_chan.top        = top_r;
  assign out_chan.right      = right_r;
  assign out_chan.bottom     = bottom_r;
  assign out_chan.class_code = cls_out_r;
  assign out_chan.win_score  = best_out_r;

endmodule

@@ sv/dad_checker.sv @@
`timescale 1ns / 1ps

module dad_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dad_pkg::EdgeW-1:0]     out_left,
  input logic [dad_pkg::EdgeW-1:0]     out_top,
  input logic [dad_pkg::EdgeW-1:0]     out_right,
  input logic [dad_pkg::EdgeW-1:0]     out_bottom,
  input logic [dad_pkg::ClassW-1:0]    out_class_code,
  input logic [dad_pkg::ScoreW-1:0]    out_win_score
);

  // stalled item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_top)
      && $stable(out_right) && $stable(out_bottom) && $stable(out_class_code)
      && $stable(out_win_score))
    else $error("stalled result item changed");

  // nothing leaves straight after reset
  assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result item right after reset");

  // only kept dataset classes
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_class_code == dad_pkg::CLS_PERSON
      || out_class_code == dad_pkg::CLS_BICYCLE || out_class_code == dad_pkg::CLS_CAR
      || out_class_code == dad_pkg::CLS_MOTORCYCLE || out_class_code == dad_pkg::CLS_BUS
      || out_class_code == dad_pkg::CLS_TRUCK))
    else $error("class code outside kept classes");

  // edges ordered, winner nonzero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_left <= out_right && out_top <= out_bottom)
    else $error("box edges out of order");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_win_score != '0)
    else $error("result item with zero score");

endmodule

bind detection_anchor_decode_top dad_checker u_dad_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_left       (out_chan.left),
  .out_top        (out_chan.top),
  .out_right      (out_chan.right),
  .out_bottom     (out_chan.bottom),
  .out_class_code (out_chan.class_code),
  .out_win_score  (out_chan.win_score)
);
